/* rtl/tdpt_pkg.sv */
package tdpt_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	localparam value_t SMALLEST_PRIME = value_t'(2);
	localparam value_t FIRST_ODD_DIV  = value_t'(3);
	localparam value_t ODD_STEP       = value_t'(2);
	localparam cnt_t   LAST_BIT       = cnt_t'(VALUE_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_REPORT
	} state_t;

endpackage

/* rtl/tdpt_if.sv */
interface tdpt_query_if;
	logic              valid;
	logic              ready;
	tdpt_pkg::value_t  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_answer_if;
	logic valid;
	logic ready;
	logic is_prime;
	logic bad_input;

	modport source (output valid, output is_prime, output bad_input, input ready);
	modport sink   (input valid, input is_prime, input bad_input, output ready);
endinterface

/* rtl/tdpt_div.sv */
module tdpt_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tdpt_pkg::value_t dividend,
	input  tdpt_pkg::value_t divisor,
	output logic             busy,
	output logic             done,
	output tdpt_pkg::value_t quotient,
	output tdpt_pkg::value_t remainder
);

	logic                              busy_q;
	logic                              done_q;
	tdpt_pkg::cnt_t                    cnt_q;
	tdpt_pkg::value_t                  rem_q;
	tdpt_pkg::value_t                  dq_q;
	tdpt_pkg::value_t                  dvs_q;
	logic [tdpt_pkg::VALUE_WIDTH:0]    trial;
	logic [tdpt_pkg::VALUE_WIDTH:0]    diff;
	logic                              ge;
	tdpt_pkg::value_t                  rem_nxt;

	always_comb begin
		trial   = {rem_q, dq_q[tdpt_pkg::VALUE_WIDTH-1]};
		diff    = trial - {1'b0, dvs_q};
		ge      = !diff[tdpt_pkg::VALUE_WIDTH];
		rem_nxt = ge ? diff[tdpt_pkg::VALUE_WIDTH-1:0] : trial[tdpt_pkg::VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tdpt_pkg::LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[tdpt_pkg::VALUE_WIDTH-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

/* rtl/trial_division_prime_test.sv */
// channel  | role   | payload
// ---------+--------+------------------------------------
// query    | sink   | value     [VALUE_WIDTH-1:0] unsigned
// answer   | source | is_prime, bad_input
//
// Values below two, and even values from four up, answer without the divider.
// Other values run one odd divisor at a time, from three upward, through a
// shared restoring divider until a divisor divides the value or exceeds its
// quotient; the block then reports whether the value is prime.
// Reset clears the sequencer and the answer valid flag; no clearing pass.
// query.ready is high only while idle; a stalled answer holds the block
// in its report state with the next result waiting.
module trial_division_prime_test (
	input logic          clk,
	input logic          arst_n,
	tdpt_query_if.sink   query,
	tdpt_answer_if.source answer
);

	tdpt_pkg::state_t state_q, state_d;
	tdpt_pkg::value_t val_q, val_d;
	tdpt_pkg::value_t d_q, d_d;
	logic             rp_q, rp_d;
	logic             rb_q, rb_d;
	logic             out_valid_q;
	logic             out_prime_q;
	logic             out_bad_q;
	logic             load_out;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	tdpt_pkg::value_t div_dividend;
	tdpt_pkg::value_t div_quo;
	tdpt_pkg::value_t div_rem;

	assign div_dividend = (state_q == tdpt_pkg::ST_IDLE) ? query.value : val_q;

	tdpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (d_d),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		state_d     = state_q;
		val_d       = val_q;
		d_d         = d_q;
		rp_d        = rp_q;
		rb_d        = rb_q;
		div_start   = 1'b0;
		load_out    = 1'b0;
		query.ready = 1'b0;
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				query.ready = 1'b1;
				if (query.valid) begin
					val_d = query.value;
					d_d   = tdpt_pkg::FIRST_ODD_DIV;
					rp_d  = 1'b0;
					rb_d  = 1'b0;
					if (query.value < tdpt_pkg::SMALLEST_PRIME) begin
						rb_d    = 1'b1;
						state_d = tdpt_pkg::ST_REPORT;
					end else if (query.value > tdpt_pkg::SMALLEST_PRIME &&
					             !query.value[0]) begin
						state_d = tdpt_pkg::ST_REPORT;
					end else begin
						div_start = 1'b1;
						state_d   = tdpt_pkg::ST_DIV;
					end
				end
			end
			tdpt_pkg::ST_DIV: begin
				if (div_done) begin
					if (d_q > div_quo) begin
						rp_d    = 1'b1;
						state_d = tdpt_pkg::ST_REPORT;
					end else if (div_rem == '0) begin
						rp_d    = 1'b0;
						state_d = tdpt_pkg::ST_REPORT;
					end else begin
						d_d       = d_q + tdpt_pkg::ODD_STEP;
						div_start = 1'b1;
					end
				end
			end
			tdpt_pkg::ST_REPORT: begin
				if (!out_valid_q || answer.ready) begin
					load_out = 1'b1;
					state_d  = tdpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdpt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (answer.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		d_q   <= d_d;
		rp_q  <= rp_d;
		rb_q  <= rb_d;
		if (load_out) begin
			out_prime_q <= rp_q;
			out_bad_q   <= rb_q;
		end
	end

	assign answer.valid     = out_valid_q;
	assign answer.is_prime  = out_prime_q;
	assign answer.bad_input = out_bad_q;

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tdpt_pkg::ST_IDLE |-> !div_busy && !div_done)
		else $error("divider active while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		query.valid && query.ready |=> state_q != tdpt_pkg::ST_IDLE)
		else $error("accepted beat left sequencer idle");

	a_bad_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		answer.valid |-> !(answer.is_prime && answer.bad_input))
		else $error("bad input reported prime");

endmodule

/* sim/trial_division_prime_test_test.sv */
`timescale 1ns / 1ps

module trial_division_prime_test_test;

	typedef struct {
		tdpt_pkg::value_t value;
		logic             is_prime;
		logic             bad_input;
	} answer_entry_t;

	typedef struct {
		tdpt_pkg::value_t value;
		bit               typed;
		logic             is_prime;
		logic             bad_input;
	} query_row_t;

	localparam int RANDOM_QUERIES = 80;
	localparam int DIRECTED_COUNT = 19;
	localparam int HOLD_OFF_AT    = 30;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int DRAIN_CYCLES   = 50;

	logic clk;
	logic arst_n;

	tdpt_query_if  query_bus ();
	tdpt_answer_if answer_bus ();

	trial_division_prime_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_bus),
		.answer (answer_bus)
	);

	answer_entry_t pending_answers[$];
	int            fail_count = 0;
	int            answers_seen = 0;

	query_row_t directed_rows [DIRECTED_COUNT] = '{
		'{tdpt_pkg::value_t'(0),            1'b1, 1'b0, 1'b1},
		'{tdpt_pkg::value_t'(1),            1'b1, 1'b0, 1'b1},
		'{tdpt_pkg::value_t'(2),            1'b1, 1'b1, 1'b0},
		'{tdpt_pkg::value_t'(3),            1'b1, 1'b1, 1'b0},
		'{tdpt_pkg::value_t'(4),            1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(9),            1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(25),           1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(63001),        1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(32'hFFFFFFFE), 1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(32'h80000000), 1'b1, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(32'hFFFFFFFF), 1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(32'h55555555), 1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(32'hAAAAAAAB), 1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(5),            1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(15),           1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(97),           1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(65536),        1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(1048573),      1'b0, 1'b0, 1'b0},
		'{tdpt_pkg::value_t'(65537),        1'b0, 1'b0, 1'b0}
	};

	function automatic answer_entry_t primality_of(tdpt_pkg::value_t v);
		answer_entry_t    res;
		longint unsigned  wide;
		longint unsigned  divisor;
		bit               composite;
		res.value     = v;
		res.is_prime  = 1'b0;
		res.bad_input = 1'b0;
		wide          = longint'(v);
		composite     = 1'b0;
		if (v < tdpt_pkg::SMALLEST_PRIME) begin
			res.bad_input = 1'b1;
		end else begin
			if (v > tdpt_pkg::SMALLEST_PRIME && !v[0])
				composite = 1'b1;
			divisor = longint'(tdpt_pkg::FIRST_ODD_DIV);
			while (!composite && divisor <= wide / divisor) begin
				if (wide % divisor == 0)
					composite = 1'b1;
				divisor += longint'(tdpt_pkg::ODD_STEP);
			end
			res.is_prime = !composite;
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(30, 150);
	endfunction

	function automatic tdpt_pkg::value_t draw_value();
		int               r;
		tdpt_pkg::value_t full;
		r    = $urandom_range(0, 99);
		full = $urandom();
		if (r < 40)
			return tdpt_pkg::value_t'($urandom_range(0, 4095));
		else if (r < 60)
			return tdpt_pkg::value_t'($urandom_range(0, 65535));
		else if (r < 70)
			return tdpt_pkg::value_t'($urandom_range(0, (1 << 20) - 1));
		else if (r < 85)
			return full & ~tdpt_pkg::value_t'(1);
		else
			return full - (full % 3);
	endfunction

	task automatic offer_query(tdpt_pkg::value_t v, answer_entry_t want, bit eager);
		int gap;
		gap = eager ? 0 : pick_gap();
		if (gap > 0) begin
			query_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_bus.valid <= 1'b1;
		query_bus.value <= v;
		@(posedge clk);
		while (!query_bus.ready)
			@(posedge clk);
		pending_answers.push_back(want);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("trial_division_prime_test verification failed");
		$finish;
	end

	initial begin
		int            stall;
		answer_entry_t want;
		answer_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (answers_seen == HOLD_OFF_AT)
				stall = HOLD_OFF_LEN;
			else if (answers_seen >= 60 && answers_seen < 80)
				stall = 0;
			else
				stall = pick_gap();
			if (stall > 0) begin
				answer_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			answer_bus.ready <= 1'b1;
			@(posedge clk);
			while (!answer_bus.valid)
				@(posedge clk);
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("answer beat with nothing pending: is_prime %0b bad_input %0b",
					answer_bus.is_prime, answer_bus.bad_input);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (answer_bus.is_prime !== want.is_prime) begin
					$error("is_prime for %0d: expected %0b, got %0b",
						want.value, want.is_prime, answer_bus.is_prime);
					fail_count++;
				end
				if (answer_bus.bad_input !== want.bad_input) begin
					$error("bad_input for %0d: expected %0b, got %0b",
						want.value, want.bad_input, answer_bus.bad_input);
					fail_count++;
				end
			end
		end
	end

	initial begin
		answer_entry_t    want;
		tdpt_pkg::value_t v;
		arst_n          <= 1'b0;
		query_bus.valid <= 1'b0;
		query_bus.value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			if (directed_rows[i].typed) begin
				want.value     = directed_rows[i].value;
				want.is_prime  = directed_rows[i].is_prime;
				want.bad_input = directed_rows[i].bad_input;
			end else begin
				want = primality_of(directed_rows[i].value);
			end
			offer_query(directed_rows[i].value, want, 1'b0);
		end

		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			v = draw_value();
			offer_query(v, primality_of(v), i >= 40 && i < 60);
		end
		query_bus.valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("trial_division_prime_test verification clean");
		else
			$display("trial_division_prime_test verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/tdpt_pkg.sv
rtl/tdpt_if.sv
rtl/tdpt_div.sv
rtl/trial_division_prime_test.sv
sim/trial_division_prime_test_test.sv
